// ----- hw/rtl/ppne_pkg.sv -----
package ppne_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEADBAND         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL_SPACING  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSED_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPEN_THRESHOLD   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VELOCITY_GAIN    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL_ENABLE   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL_NUMBER   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEDAL_NOTE       = 3'd7;

    localparam logic [11:0] DEADBAND_RESET         = 12'd100;
    localparam logic [7:0]  CONTROL_SPACING_RESET  = 8'd5;
    localparam logic [11:0] CLOSED_THRESHOLD_RESET = 12'd700;
    localparam logic [11:0] OPEN_THRESHOLD_RESET   = 12'd1200;
    localparam logic [7:0]  VELOCITY_GAIN_RESET    = 8'd1;
    localparam logic        CONTROL_ENABLE_RESET   = 1'b1;
    localparam logic [6:0]  CONTROL_NUMBER_RESET   = 7'd4;
    localparam logic [6:0]  PEDAL_NOTE_RESET       = 7'd44;

    localparam int PEAK_RESET = 2000;

    localparam logic [6:0] MIDI_MAX = 7'd127;

    localparam logic [1:0] PAD_UNCHANGED = 2'd0;
    localparam logic [1:0] PAD_CLOSED    = 2'd1;
    localparam logic [1:0] PAD_OPEN      = 2'd2;

    typedef struct packed {
        logic [11:0] deadband;
        logic [7:0]  control_spacing;
        logic [11:0] closed_threshold;
        logic [11:0] open_threshold;
        logic [7:0]  velocity_gain;
        logic        control_enable;
        logic [6:0]  control_number;
        logic [6:0]  pedal_note;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_VEL,
        ST_CTL,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/ppne_cfg.sv -----
module ppne_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppne_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ppne_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output ppne_pkg::t_cfg                      o_cfg
);
    import ppne_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband         <= DEADBAND_RESET;
            r_cfg.control_spacing  <= CONTROL_SPACING_RESET;
            r_cfg.closed_threshold <= CLOSED_THRESHOLD_RESET;
            r_cfg.open_threshold   <= OPEN_THRESHOLD_RESET;
            r_cfg.velocity_gain    <= VELOCITY_GAIN_RESET;
            r_cfg.control_enable   <= CONTROL_ENABLE_RESET;
            r_cfg.control_number   <= CONTROL_NUMBER_RESET;
            r_cfg.pedal_note       <= PEDAL_NOTE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEADBAND:         r_cfg.deadband         <= i_cfg_data[11:0];
                CFG_CONTROL_SPACING:  r_cfg.control_spacing  <= i_cfg_data[7:0];
                CFG_CLOSED_THRESHOLD: r_cfg.closed_threshold <= i_cfg_data[11:0];
                CFG_OPEN_THRESHOLD:   r_cfg.open_threshold   <= i_cfg_data[11:0];
                CFG_VELOCITY_GAIN:    r_cfg.velocity_gain    <= i_cfg_data[7:0];
                CFG_CONTROL_ENABLE:   r_cfg.control_enable   <= i_cfg_data[0];
                CFG_CONTROL_NUMBER:   r_cfg.control_number   <= i_cfg_data[6:0];
                CFG_PEDAL_NOTE:       r_cfg.pedal_note       <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/ppne_div.sv -----
module ppne_div #(
    parameter int DW = 19,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CNT_BITS = $clog2(DW + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [VW-1:0]       r_rem;
    logic [VW-1:0]       r_div;
    logic [DW-1:0]       r_quo;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          take;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_div};
        take  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= (i_divisor == '0) ? VW'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/pedal_position_to_note_events.sv -----
// Each accepted sample passes through EVAL, then up to two divisions (velocity, then control),
// then DONE; a new sample is taken only once the last one is back in IDLE.
// Both divisions use one shared radix-2 divider in turn; a stalled result holds DONE
// until the output register is free.
// Reset: synchronous, active low; resets state, counters, the output valid flag and
// the configuration registers.
module pedal_position_to_note_events #(
    parameter int SAMPLE_BITS = ppne_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = ppne_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_note_valid,
    output logic [6:0]                          o_note_number,
    output logic [6:0]                          o_note_velocity,
    output logic                                o_control_valid,
    output logic [6:0]                          o_control_id,
    output logic [6:0]                          o_control_value,
    output logic [1:0]                          o_pad_select,
    input  logic                                i_cfg_we,
    input  logic [ppne_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ppne_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ppne_pkg::*;

    localparam int CW = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;
    localparam int DW = SAMPLE_BITS + 7;
    localparam int VW = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int PEAK_INIT = (PEAK_RESET > SAMPLE_MAX) ? SAMPLE_MAX : PEAK_RESET;

    t_cfg cfg;

    ppne_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    t_state r_state;
    t_state n_state;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SAMPLE_BITS-1:0] r_last;
    logic                   r_closed;
    logic [COUNT_BITS-1:0]  r_upd_cnt;
    logic [COUNT_BITS-1:0]  r_ctl_cnt;
    logic                   r_do_note;
    logic                   r_do_ctl;
    logic [1:0]             r_pad;
    logic [6:0]             r_vel;
    logic [6:0]             r_cval;

    logic                   r_out_valid;
    logic                   r_out_note_valid;
    logic [6:0]             r_out_note_number;
    logic [6:0]             r_out_note_velocity;
    logic                   r_out_control_valid;
    logic [6:0]             r_out_control_id;
    logic [6:0]             r_out_control_value;
    logic [1:0]             r_out_pad;

    logic [CW-1:0]         s_ext;
    logic [CW-1:0]         last_ext;
    logic [CW-1:0]         db_ext;
    logic                  upd;
    logic                  n_do_note;
    logic                  n_do_open;
    logic                  n_do_ctl;
    logic [COUNT_BITS-1:0] upd_base;
    logic [COUNT_BITS-1:0] ctl_base;

    logic                  accept;
    logic                  div_start;
    logic                  sel_ctl;
    logic                  out_load;
    logic [DW-1:0]         div_dividend;
    logic [VW-1:0]         div_divisor;
    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic [DW-1:0]         s_x127;

    always_comb begin
        s_ext    = CW'(r_sample);
        last_ext = CW'(r_last);
        db_ext   = CW'(cfg.deadband);
        upd = (last_ext > s_ext + db_ext) || (last_ext + db_ext < s_ext);
        n_do_note = upd && (s_ext < CW'(cfg.closed_threshold)) && !r_closed;
        n_do_open = upd && (s_ext > CW'(cfg.open_threshold));
        n_do_ctl  = upd && cfg.control_enable
                    && (r_ctl_cnt >= COUNT_BITS'(cfg.control_spacing));
        upd_base = upd ? '0 : r_upd_cnt;
        ctl_base = n_do_ctl ? '0 : r_ctl_cnt;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (n_do_note) begin
                    n_state = ST_VEL;
                end else if (n_do_ctl) begin
                    n_state = ST_CTL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_VEL: begin
                if (div_done) begin
                    n_state = r_do_ctl ? ST_CTL : ST_DONE;
                end
            end
            ST_CTL: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        div_start = 1'b0;
        sel_ctl   = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_EVAL: begin
                div_start = n_do_note || n_do_ctl;
                sel_ctl   = !n_do_note;
            end
            ST_VEL: begin
                div_start = div_done && r_do_ctl;
                sel_ctl   = 1'b1;
            end
            ST_CTL: ;
            ST_DONE: out_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    assign accept = i_valid && o_ready;
    assign s_x127 = {r_sample, 7'd0} - DW'(r_sample);

    always_comb begin
        if (sel_ctl) begin
            div_dividend = s_x127;
            div_divisor  = VW'(r_peak);
        end else begin
            div_dividend = DW'({cfg.velocity_gain, 7'd0});
            div_divisor  = VW'(r_upd_cnt);
        end
    end

    ppne_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_peak      <= SAMPLE_BITS'(PEAK_INIT);
            r_last      <= '0;
            r_closed    <= 1'b0;
            r_upd_cnt   <= '0;
            r_ctl_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && (i_sample > r_peak)) begin
                r_peak <= i_sample;
            end
            if (r_state == ST_EVAL) begin
                if (upd) begin
                    r_last <= r_sample;
                end
                if (n_do_open) begin
                    r_closed <= 1'b0;
                end else if (n_do_note) begin
                    r_closed <= 1'b1;
                end
                r_upd_cnt <= (upd_base == '1) ? upd_base : upd_base + COUNT_BITS'(1);
                r_ctl_cnt <= (ctl_base == '1) ? ctl_base : ctl_base + COUNT_BITS'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        if (r_state == ST_EVAL) begin
            r_do_note <= n_do_note;
            r_do_ctl  <= n_do_ctl;
            r_vel     <= '0;
            r_cval    <= '0;
            priority if (n_do_open) begin
                r_pad <= PAD_OPEN;
            end else if (n_do_note) begin
                r_pad <= PAD_CLOSED;
            end else begin
                r_pad <= PAD_UNCHANGED;
            end
        end
        if ((r_state == ST_VEL) && div_done) begin
            r_vel <= (div_quo > DW'(MIDI_MAX)) ? MIDI_MAX : div_quo[6:0];
        end
        if ((r_state == ST_CTL) && div_done) begin
            r_cval <= MIDI_MAX - ((div_quo > DW'(MIDI_MAX)) ? MIDI_MAX : div_quo[6:0]);
        end
        if (out_load) begin
            r_out_note_valid    <= r_do_note;
            r_out_note_number   <= r_do_note ? cfg.pedal_note : 7'd0;
            r_out_note_velocity <= r_vel;
            r_out_control_valid <= r_do_ctl;
            r_out_control_id    <= r_do_ctl ? cfg.control_number : 7'd0;
            r_out_control_value <= r_cval;
            r_out_pad           <= r_pad;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_note_valid    = r_out_note_valid;
    assign o_note_number   = r_out_note_number;
    assign o_note_velocity = r_out_note_velocity;
    assign o_control_valid = r_out_control_valid;
    assign o_control_id    = r_out_control_id;
    assign o_control_value = r_out_control_value;
    assign o_pad_select    = r_out_pad;

endmodule
